>>> rtl/mf9_pkg.sv
// Package for the streaming 9x9 median filter.
// Shared constants, payload structs and the rank-cell bus; no dependencies.
`default_nettype none
package mf9_pkg;

	localparam int RADIUS    = 4;
	localparam int WIN       = 2 * RADIUS + 1;
	localparam int AREA      = WIN * WIN;
	localparam int LINES     = 2 * RADIUS;
	localparam int MAX_WIDTH = 1024;
	localparam int RANK      = AREA / 2;

	localparam int PIX_W  = 8;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = 11;
	localparam int ROW_W  = 12;
	localparam int CFG_W  = 12;
	localparam int RANK_W = $clog2(AREA + 1);
	localparam int CNT_W  = $clog2(WIN + 1);
	localparam int LB_W   = LINES * PIX_W;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             frame_start;
	} pixel_req_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_column;
		logic [PIX_W-1:0] median_value;
	} median_rsp_t;

	// Data handed from one rank cell to the next
	typedef struct packed {
		logic [AREA-1:0][PIX_W-1:0] values;
		logic [AREA-1:0]            active;
		logic [RANK_W-1:0]          rank;
		logic [PIX_W-1:0]           median;
		logic [ROW_W-1:0]           row;
		logic [COL_W-1:0]           col;
	} cell_bus_t;

endpackage
`default_nettype wire

>>> rtl/mf9_line_buf.sv
// Line store: one word per column holding the previous lines' pixels.
// Depends on mf9_pkg.
`default_nettype none
module mf9_line_buf (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [mf9_pkg::COL_W-1:0] rd_addr,
	output logic      [mf9_pkg::LB_W-1:0]  rd_data,
	input  wire logic                      wr_en,
	input  wire logic [mf9_pkg::COL_W-1:0] wr_addr,
	input  wire logic [mf9_pkg::LB_W-1:0]  wr_data
);
	import mf9_pkg::*;

	logic [LB_W-1:0] mem [MAX_WIDTH];

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/mf9_rank_cell.sv
// One rank-select cell: decides one median bit, MSB-first, in two stages.
// Depends on mf9_pkg.
`default_nettype none
module mf9_rank_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic [2:0]            bit_idx,
	input  wire logic                  valid_in,
	input  wire mf9_pkg::cell_bus_t    bus_in,
	output logic                       valid_out,
	output mf9_pkg::cell_bus_t         bus_out
);
	import mf9_pkg::*;

	logic                       v_s1;
	cell_bus_t                  bus_s1;
	logic [WIN-1:0][CNT_W-1:0]  cnt_s1;
	logic [WIN-1:0][CNT_W-1:0]  cnt_d;
	logic [RANK_W-1:0]          zeros;
	logic                       bit_one;
	cell_bus_t                  bus_d;

	// stage 1: count active values with a zero at this bit, per group
	always_comb begin
		for (int g = 0; g < WIN; g++) begin
			cnt_d[g] = '0;
			for (int i = 0; i < WIN; i++) begin
				cnt_d[g] = cnt_d[g] + CNT_W'(bus_in.active[g*WIN+i]
					& ~bus_in.values[g*WIN+i][bit_idx]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bus_s1 <= bus_in;
			cnt_s1 <= cnt_d;
		end
	end

	// stage 2: total, pick the bit, narrow the candidates
	always_comb begin
		zeros = '0;
		for (int g = 0; g < WIN; g++) begin
			zeros = zeros + RANK_W'(cnt_s1[g]);
		end
		bit_one = (bus_s1.rank >= zeros);
		bus_d = bus_s1;
		bus_d.median[bit_idx] = bit_one;
		if (bit_one) begin
			bus_d.rank = bus_s1.rank - zeros;
		end
		for (int i = 0; i < AREA; i++) begin
			bus_d.active[i] = bus_s1.active[i] & (bus_s1.values[i][bit_idx] == bit_one);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (adv) begin
			valid_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bus_out <= bus_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/median_filter_9x9_top.sv
// Top level of the streaming 9x9 median filter.
// Depends on mf9_pkg, mf9_line_buf and mf9_rank_cell.
`default_nettype none
// Takes one pixel per clock in raster order and gives, for every pixel at
// least four from each edge, its row, column and the median (41st smallest)
// of its 9x9 neighborhood. Border positions give no result. The result for
// a window passes, after the pixel that completes it is accepted, through
// the stage-1 line-store read, then the window shift register, and then
// each of the eight bit cells of the rank chain in turn. The line store is
// read and written once per pixel at the pixel's column, one word per
// column holding eight lines. All stages advance together whenever the
// output register is empty or being taken, so a stalled output stalls
// the input.
module median_filter_9x9_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire mf9_pkg::pixel_req_t       in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output mf9_pkg::median_rsp_t           out_data,
	input  wire logic                      cfg_we,
	input  wire logic [0:0]                cfg_index,
	input  wire logic [mf9_pkg::CFG_W-1:0] cfg_wdata
);
	import mf9_pkg::*;

	logic [WID_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [WID_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic             adv;
	logic             accept;
	logic [COL_W-1:0] c_cur;
	logic [ROW_W:0]   r_ext;
	logic [ROW_W-1:0] r_cur;
	logic [WID_W-1:0] c_nxt;
	logic [ROW_W:0]   r_nxt;
	logic [COL_W-1:0] col_d;
	logic [ROW_W-1:0] row_d;
	logic             emit;

	logic             v_s1;
	logic             emit_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic [LB_W-1:0]  lb_rdata;

	logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_q;
	logic             v_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;

	logic [PIX_W:0]   cv;
	cell_bus_t        cb [PIX_W+1];

	assign adv    = !out_valid || out_ready;
	assign in_ready = adv;
	assign accept = in_valid && adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(256);
			height_q <= ROW_W'(256);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata[WID_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective frame size
	always_comb begin
		w_eff = width_q;
		if (width_q == '0) begin
			w_eff = WID_W'(1);
		end else if (width_q > WID_W'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end
		h_eff = (height_q == '0) ? ROW_W'(1) : height_q;
	end

	// position of the incoming pixel and of the next one
	always_comb begin
		c_cur = in_data.frame_start ? '0 : col_q;
		r_ext = in_data.frame_start ? '0 : {1'b0, row_q};
		if ({1'b0, c_cur} >= w_eff) begin
			c_cur = '0;
			r_ext = r_ext + 1'b1;
		end
		if (r_ext >= {1'b0, h_eff}) begin
			r_ext = '0;
		end
		r_cur = r_ext[ROW_W-1:0];
		c_nxt = {1'b0, c_cur} + 1'b1;
		r_nxt = {1'b0, r_cur} + 1'b1;
		if (c_nxt >= w_eff) begin
			col_d = '0;
			row_d = (r_nxt >= {1'b0, h_eff}) ? '0 : r_nxt[ROW_W-1:0];
		end else begin
			col_d = c_nxt[COL_W-1:0];
			row_d = r_cur;
		end
		emit = (r_cur >= ROW_W'(LINES)) && (c_cur >= COL_W'(LINES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= row_d;
			col_q <= col_d;
		end
	end

	// stage 1: line-store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			pix_s1  <= in_data.pixel_value;
			row_s1  <= r_cur;
			col_s1  <= c_cur;
		end
	end

	mf9_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (c_cur),
		.rd_data (lb_rdata),
		.wr_en   (adv && v_s1),
		.wr_addr (col_s1),
		.wr_data ({lb_rdata[LB_W-PIX_W-1:0], pix_s1})
	);

	// stage 2: window shift, newest column enters on the right
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			for (int k = 0; k < WIN; k++) begin
				for (int j = 0; j < WIN - 1; j++) begin
					win_q[k][j] <= win_q[k][j+1];
				end
			end
			for (int k = 0; k < LINES; k++) begin
				win_q[k][WIN-1] <= lb_rdata[(LINES-1-k)*PIX_W +: PIX_W];
			end
			win_q[WIN-1][WIN-1] <= pix_s1;
			row_s2 <= row_s1 - ROW_W'(RADIUS);
			col_s2 <= col_s1 - COL_W'(RADIUS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	// rank chain input
	always_comb begin
		cb[0].values = win_q;
		cb[0].active = '1;
		cb[0].rank   = RANK_W'(RANK);
		cb[0].median = '0;
		cb[0].row    = row_s2;
		cb[0].col    = col_s2;
	end
	assign cv[0] = v_s2;

	for (genvar i = 0; i < PIX_W; i++) begin : g_cell
		mf9_rank_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.bit_idx   (3'(PIX_W - 1 - i)),
			.valid_in  (cv[i]),
			.bus_in    (cb[i]),
			.valid_out (cv[i+1]),
			.bus_out   (cb[i+1])
		);
	end

	assign out_valid             = cv[PIX_W];
	assign out_data.out_row      = cb[PIX_W].row;
	assign out_data.out_column   = cb[PIX_W].col;
	assign out_data.median_value = cb[PIX_W].median;

`ifndef ASSERT_OFF
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.frame_start |=> v_s1 && row_s1 == '0 && col_s1 == '0)
		else $error("frame start did not restart position");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_we |=> {1'b0, col_q} < w_eff)
		else $error("column counter past line width");
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.out_row >= ROW_W'(RADIUS)
			&& out_data.out_column >= COL_W'(RADIUS))
		else $error("result for a border position");
`endif

endmodule
`default_nettype wire
